// ===== sv/mavt_pkg.sv =====
// ----------------------------------------------------------------------------
// mavt_pkg
// Shared types and constants of the multi-turn angle and velocity tracker:
// configuration register map, register layout and reset values.
// ----------------------------------------------------------------------------
package mavt_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;
    localparam int POLES_BITS    = 7;
    localparam int OFFSET_BITS   = 14;
    localparam int RATE_BITS     = 17;
    localparam int VEL_BITS      = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DIR    = 2'd0,
        CFG_POLES  = 2'd1,
        CFG_OFFSET = 2'd2,
        CFG_RATE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                   direction_reversed;
        logic [POLES_BITS-1:0]  pole_pairs;
        logic [OFFSET_BITS-1:0] zero_electric_offset;
        logic [RATE_BITS-1:0]   sample_rate_hz;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        direction_reversed:   1'b0,
        pole_pairs:           7'd7,
        zero_electric_offset: 14'd0,
        sample_rate_hz:       17'd20000
    };

endpackage

// ===== sv/mavt_turn.sv =====
// ----------------------------------------------------------------------------
// mavt_turn
// Turn counting state: keeps the previous angle and the wrapping turn count,
// and gives the multi-turn position and the position change of each item.
// ----------------------------------------------------------------------------
module mavt_turn #(
    parameter int ANGLE_BITS = 14,
    parameter int TURN_BITS  = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [ANGLE_BITS-1:0]           i_angle,
    output logic [TURN_BITS+ANGLE_BITS-1:0] o_position,
    output logic signed [ANGLE_BITS+1:0]    o_dpos
);

    // a jump counts a turn when |delta| * 5 > 4 * one turn
    localparam logic [ANGLE_BITS+2:0] JUMP_THR = {3'b100, {ANGLE_BITS{1'b0}}};
    localparam logic signed [ANGLE_BITS+1:0] TURN_DEC = {2'b11, {ANGLE_BITS{1'b0}}};
    localparam logic signed [ANGLE_BITS+1:0] TURN_INC = {2'b01, {ANGLE_BITS{1'b0}}};

    logic                          r_primed;
    logic [ANGLE_BITS-1:0]         r_prev;
    logic [TURN_BITS-1:0]          r_turn;
    logic [TURN_BITS-1:0]          n_turn;

    logic signed [ANGLE_BITS:0]    d;
    logic [ANGLE_BITS-1:0]         mag;
    logic [ANGLE_BITS+2:0]         mag5;
    logic                          jump;
    logic                          turn_dn;
    logic                          turn_up;
    logic signed [ANGLE_BITS+1:0]  d_ext;
    logic signed [ANGLE_BITS+1:0]  step;

    assign d    = $signed({1'b0, i_angle}) - $signed({1'b0, r_prev});
    assign mag  = d[ANGLE_BITS] ? ANGLE_BITS'(-d) : d[ANGLE_BITS-1:0];
    assign mag5 = {mag, 2'b00} + (ANGLE_BITS+3)'(mag);
    assign jump = r_primed && (mag5 > JUMP_THR);

    // a large positive jump means the angle wrapped backward
    assign turn_dn = jump && !d[ANGLE_BITS];
    assign turn_up = jump && d[ANGLE_BITS];

    always_comb begin
        if (turn_dn) begin
            n_turn = r_turn - TURN_BITS'(1);
            step   = TURN_DEC;
        end else if (turn_up) begin
            n_turn = r_turn + TURN_BITS'(1);
            step   = TURN_INC;
        end else begin
            n_turn = r_turn;
            step   = '0;
        end
    end

    assign d_ext      = (ANGLE_BITS+2)'(d);
    assign o_dpos     = r_primed ? d_ext + step : '0;
    assign o_position = {n_turn, i_angle};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_prev   <= '0;
            r_turn   <= '0;
        end else if (i_en) begin
            r_primed <= 1'b1;
            r_prev   <= i_angle;
            r_turn   <= n_turn;
        end
    end

endmodule

// ===== sv/mavt_elec.sv =====
// ----------------------------------------------------------------------------
// mavt_elec
// Electrical angle: pole pairs times mechanical angle, sign by direction,
// minus the zero offset, all modulo one turn.
// ----------------------------------------------------------------------------
module mavt_elec #(
    parameter int ANGLE_BITS = 14
) (
    input  mavt_pkg::t_cfg         i_cfg,
    input  logic [ANGLE_BITS-1:0]  i_angle,
    output logic [ANGLE_BITS-1:0]  o_elec
);

    import mavt_pkg::*;

    logic [ANGLE_BITS+POLES_BITS-1:0] prod;
    logic [ANGLE_BITS-1:0]            e_mech;
    logic [ANGLE_BITS-1:0]            e_dir;

    assign prod   = (ANGLE_BITS+POLES_BITS)'(i_cfg.pole_pairs)
                  * (ANGLE_BITS+POLES_BITS)'(i_angle);
    assign e_mech = prod[ANGLE_BITS-1:0];
    assign e_dir  = i_cfg.direction_reversed ? ANGLE_BITS'(0) - e_mech : e_mech;
    assign o_elec = e_dir - ANGLE_BITS'(i_cfg.zero_electric_offset);

endmodule

// ===== sv/mavt_vel.sv =====
// ----------------------------------------------------------------------------
// mavt_vel
// Velocity: position change times sample rate, saturated to signed 32 bits.
// ----------------------------------------------------------------------------
module mavt_vel #(
    parameter int ANGLE_BITS = 14
) (
    input  logic signed [ANGLE_BITS+1:0]      i_dpos,
    input  logic [mavt_pkg::RATE_BITS-1:0]    i_rate,
    output logic [mavt_pkg::VEL_BITS-1:0]     o_vel
);

    import mavt_pkg::*;

    localparam int PW = ANGLE_BITS + 2 + RATE_BITS + 1;
    localparam int EW = (PW > VEL_BITS) ? PW : VEL_BITS;
    localparam logic signed [EW-1:0] VMAX = EW'(32'sh7FFF_FFFF);
    localparam logic signed [EW-1:0] VMIN = EW'(signed'(32'h8000_0000));

    logic signed [PW-1:0] prod;
    logic signed [EW-1:0] prod_ext;

    assign prod     = i_dpos * $signed({1'b0, i_rate});
    assign prod_ext = EW'(prod);

    always_comb begin
        if (prod_ext > VMAX) begin
            o_vel = VMAX[VEL_BITS-1:0];
        end else if (prod_ext < VMIN) begin
            o_vel = VMIN[VEL_BITS-1:0];
        end else begin
            o_vel = prod_ext[VEL_BITS-1:0];
        end
    end

endmodule

// ===== sv/multiturn_angle_velocity_tracker.sv =====
// ----------------------------------------------------------------------------
// multiturn_angle_velocity_tracker
// Multi-turn position, velocity and electrical angle from one absolute
// single-turn angle sample per item.
//
//  channel  | direction | handshake                         | payload
//  ---------+-----------+-----------------------------------+---------------------
//  s_axis   | in        | i_s_axis_tvalid / o_s_axis_tready | angle_sample
//  m_axis   | out       | o_m_axis_tvalid / i_m_axis_tready | position, velocity,
//           |           |                                   | electrical_angle
//  cfg      | in        | i_cfg_valid / o_cfg_ready         | index, data
//
// One item per cycle sustained while i_m_axis_tready stays high; an accepted item
// passes the input register, the turn/electrical stage register and, after the
// velocity multiply and saturation, the output register that drives o_m_axis_tvalid.
// Each stage holds its item while the next is full, so input is taken while a
// result waits. Ready of each stage is combinational from the stage after it.
// Reset clears the valid flags and the turn state, and loads default config.
// ----------------------------------------------------------------------------
module multiturn_angle_velocity_tracker #(
    parameter int ANGLE_BITS = 14,
    parameter int TURN_BITS  = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // [ANGLE_BITS-1:0] angle_sample
    input  logic [((ANGLE_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // position, velocity (32), electrical_angle, from bit 0 up
    output logic [((2*ANGLE_BITS+TURN_BITS+39)/8)*8-1:0] o_m_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    input  logic                                 i_cfg_valid,
    input  logic [mavt_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [mavt_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output logic                                 o_cfg_ready
);

    import mavt_pkg::*;

    localparam int POS_W = TURN_BITS + ANGLE_BITS;
    localparam int OUT_W = ((2*ANGLE_BITS+TURN_BITS+39)/8)*8;

    t_cfg r_cfg;

    logic                          r_in_vld;
    logic [ANGLE_BITS-1:0]         r_in_angle;

    logic                          r_mid_vld;
    logic [POS_W-1:0]              r_mid_pos;
    logic signed [ANGLE_BITS+1:0]  r_mid_dpos;
    logic [ANGLE_BITS-1:0]         r_mid_elec;

    logic                          r_out_vld;
    logic [POS_W-1:0]              r_out_pos;
    logic [VEL_BITS-1:0]           r_out_vel;
    logic [ANGLE_BITS-1:0]         r_out_elec;

    logic                          out_rdy;
    logic                          mid_rdy;
    logic                          in_rdy;
    logic                          in_adv;

    logic [POS_W-1:0]              pos;
    logic signed [ANGLE_BITS+1:0]  dpos;
    logic [ANGLE_BITS-1:0]         elec;
    logic [VEL_BITS-1:0]           vel;

    assign out_rdy = !r_out_vld || i_m_axis_tready;
    assign mid_rdy = !r_mid_vld || out_rdy;
    assign in_rdy  = !r_in_vld || mid_rdy;
    assign in_adv  = r_in_vld && mid_rdy;

    assign o_s_axis_tready = in_rdy;
    assign o_cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIR:    r_cfg.direction_reversed   <= i_cfg_data[0];
                CFG_POLES:  r_cfg.pole_pairs           <= i_cfg_data[POLES_BITS-1:0];
                CFG_OFFSET: r_cfg.zero_electric_offset <= i_cfg_data[OFFSET_BITS-1:0];
                CFG_RATE:   r_cfg.sample_rate_hz       <= i_cfg_data[RATE_BITS-1:0];
                default:    r_cfg                      <= r_cfg;
            endcase
        end
    end

    mavt_turn #(
        .ANGLE_BITS (ANGLE_BITS),
        .TURN_BITS  (TURN_BITS)
    ) u_turn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (in_adv),
        .i_angle    (r_in_angle),
        .o_position (pos),
        .o_dpos     (dpos)
    );

    mavt_elec #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_elec (
        .i_cfg      (r_cfg),
        .i_angle    (r_in_angle),
        .o_elec     (elec)
    );

    mavt_vel #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_vel (
        .i_dpos     (r_mid_dpos),
        .i_rate     (r_cfg.sample_rate_hz),
        .o_vel      (vel)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_rdy) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (mid_rdy) begin
                r_mid_vld <= r_in_vld;
            end
            if (out_rdy) begin
                r_out_vld <= r_mid_vld;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_rdy && i_s_axis_tvalid) begin
            r_in_angle <= i_s_axis_tdata[ANGLE_BITS-1:0];
        end
        if (in_adv) begin
            r_mid_pos  <= pos;
            r_mid_dpos <= dpos;
            r_mid_elec <= elec;
        end
        if (out_rdy && r_mid_vld) begin
            r_out_pos  <= r_mid_pos;
            r_out_vel  <= vel;
            r_out_elec <= r_mid_elec;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'({r_out_elec, r_out_vel, r_out_pos});

`ifndef SYNTH
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_in_vld)
        else $error("accepted item missing from input register");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !mid_rdy) |=> (r_in_vld && $stable(r_in_angle)))
        else $error("input register lost a stalled item");

    a_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_vld && out_rdy && (r_mid_dpos == '0)) |=> (r_out_vel == '0))
        else $error("nonzero velocity for zero position change");
`endif

endmodule

// ===== tb/sv/multiturn_angle_velocity_tracker_test.sv =====
// ----------------------------------------------------------------------------
// multiturn_angle_velocity_tracker_test
// Streams angle samples through the tracker under random sender bursts and
// receiver stalls. Each accepted sample is run through a local tracker that
// keeps its own turn count and register copy. Each result is checked field
// by field: position, velocity and electrical angle.
// ----------------------------------------------------------------------------
module multiturn_angle_velocity_tracker_test;

    import mavt_pkg::*;

    localparam int ANGLE_W   = 14;
    localparam int TURN_W    = 24;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 88;
    localparam int POS_W     = ANGLE_W + TURN_W;
    localparam int VEL_LSB   = POS_W;
    localparam int EANG_LSB  = VEL_LSB + VEL_BITS;
    localparam int TURN_SPAN = 1 << ANGLE_W;
    localparam longint VEL_MAX = 64'sd2147483647;
    localparam longint VEL_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [VEL_BITS-1:0] velocity;
        logic [ANGLE_W-1:0]  elec_angle;
    } t_track_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic [IN_W-1:0]          i_s_axis_tdata = '0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [OUT_W-1:0]         o_m_axis_tdata;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     o_cfg_ready;

    multiturn_angle_velocity_tracker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cfg_ready     (o_cfg_ready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // local copy of registers and tracking state
    logic                   cfg_dir    = CFG_RESET.direction_reversed;
    logic [POLES_BITS-1:0]  cfg_poles  = CFG_RESET.pole_pairs;
    logic [OFFSET_BITS-1:0] cfg_offset = CFG_RESET.zero_electric_offset;
    logic [RATE_BITS-1:0]   cfg_rate   = CFG_RESET.sample_rate_hz;
    logic [ANGLE_W-1:0]     last_angle = '0;
    logic [TURN_W-1:0]      turns      = '0;
    logic [TURN_W-1:0]      last_turns = '0;
    logic                   primed     = 1'b0;

    logic [IN_W-1:0] angle_queue[$];
    t_track_result   expected_results[$];
    int              mismatch_count = 0;

    int burst_left   = 0;
    int gap_left     = 0;
    int hold_request = 0;
    int hold_left    = 0;
    int stall_mode   = 0;
    int mode_left    = 0;
    int stall_tick   = 0;

    function automatic t_track_result track_angle(logic [IN_W-1:0] word);
        logic [ANGLE_W-1:0]          a;
        logic [TURN_W-1:0]           dturn;
        logic [ANGLE_W+POLES_BITS-1:0] prod;
        logic [ANGLE_W-1:0]          e;
        int                          d;
        int                          mag;
        longint                      dpos;
        longint                      v;
        t_track_result               r;
        a = word[ANGLE_W-1:0];
        v = 0;
        if (!primed) begin
            // first sample only seeds the history
            primed     = 1'b1;
            last_angle = a;
            last_turns = turns;
        end else begin
            d   = int'(a) - int'(last_angle);
            mag = (d < 0) ? -d : d;
            last_turns = turns;
            if (mag * 5 > 4 * TURN_SPAN) begin
                if (d > 0)
                    turns = turns - 1'b1;
                else
                    turns = turns + 1'b1;
            end
            dturn = turns - last_turns;
            dpos  = longint'(signed'(dturn)) * TURN_SPAN + d;
            v     = dpos * longint'(cfg_rate);
            if (v > VEL_MAX)
                v = VEL_MAX;
            if (v < VEL_MIN)
                v = VEL_MIN;
            last_angle = a;
        end
        prod = cfg_poles * a;
        e    = prod[ANGLE_W-1:0];
        if (cfg_dir)
            e = '0 - e;
        e = e - cfg_offset;
        r.position   = {turns, a};
        r.velocity   = v[VEL_BITS-1:0];
        r.elec_angle = e;
        return r;
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_results.push_back(track_angle(i_s_axis_tdata));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0 || angle_queue.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    i_s_axis_tdata  <= angle_queue.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // receiver: stall pattern changes mode every so often; long hold-off on request
    always @(posedge i_clk) begin
        stall_tick++;
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left    = hold_request - 1;
            hold_request = 0;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= 1'($urandom_range(0, 1));
                2: i_m_axis_tready <= (stall_tick % 4) != 3;
                default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_track_result exp_r;
        t_track_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.position   = o_m_axis_tdata[POS_W-1:0];
            got.velocity   = o_m_axis_tdata[VEL_LSB +: VEL_BITS];
            got.elec_angle = o_m_axis_tdata[EANG_LSB +: ANGLE_W];
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, tdata %h", $time, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.position !== exp_r.position) begin
                    $display("%0t: position expected %0d got %0d", $time,
                             $signed(exp_r.position), $signed(got.position));
                    mismatch_count++;
                end
                if (got.velocity !== exp_r.velocity) begin
                    $display("%0t: velocity expected %0d got %0d", $time,
                             $signed(exp_r.velocity), $signed(got.velocity));
                    mismatch_count++;
                end
                if (got.elec_angle !== exp_r.elec_angle) begin
                    $display("%0t: electrical angle expected %0d got %0d", $time,
                             exp_r.elec_angle, got.elec_angle);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DIR:    cfg_dir    = value[0];
            CFG_POLES:  cfg_poles  = value[POLES_BITS-1:0];
            CFG_OFFSET: cfg_offset = value[OFFSET_BITS-1:0];
            CFG_RATE:   cfg_rate   = value[RATE_BITS-1:0];
            default: ;
        endcase
    endtask

    // unused upper data bits are filled with noise
    task automatic apply_setting(bit dir, int poles, int offset, int rate);
        write_reg(CFG_DIR,    {16'($urandom()), dir});
        write_reg(CFG_POLES,  {10'($urandom()), 7'(poles)});
        write_reg(CFG_OFFSET, {3'($urandom()), 14'(offset)});
        write_reg(CFG_RATE,   17'(rate));
    endtask

    // wait until every queued sample is sent and every expected result has come out
    task automatic drain();
        while (angle_queue.size() > 0 || i_s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // rotation with random speed changes, plus some noise samples
    task automatic queue_motion(int count);
        int angle_now;
        int speed;
        angle_now = $urandom_range(0, TURN_SPAN - 1);
        speed     = int'($urandom_range(0, 6000)) - 3000;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                angle_queue.push_back(IN_W'($urandom()));
            end else begin
                if ($urandom_range(0, 15) == 0)
                    speed = int'($urandom_range(0, 16000)) - 8000;
                else if ($urandom_range(0, 3) == 0)
                    speed = speed + int'($urandom_range(0, 200)) - 100;
                angle_now = (angle_now + speed) & (TURN_SPAN - 1);
                angle_queue.push_back({2'($urandom()), 14'(angle_now)});
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: priming, extremes, jump threshold both ways, padding bits
        angle_queue.push_back(16'h0000);
        angle_queue.push_back(16'h3FFF);
        angle_queue.push_back(16'h0000);
        angle_queue.push_back(16'd13107);
        angle_queue.push_back(16'h0000);
        angle_queue.push_back(16'd13108);
        angle_queue.push_back(16'h0000);
        angle_queue.push_back(16'd13108);
        angle_queue.push_back(16'd1);
        angle_queue.push_back(16'hC000 | 16'd8192);
        angle_queue.push_back(16'h4000 | 16'd16383);
        angle_queue.push_back(16'h8000 | 16'd3276);
        angle_queue.push_back(16'd3275);
        angle_queue.push_back(16'd16383);
        angle_queue.push_back(16'hFFFF);
        angle_queue.push_back(16'h2AAA);
        angle_queue.push_back(16'h1555);
        drain();

        apply_setting(1'b1, 64, 16383, 100000);
        queue_motion(100);
        drain();

        apply_setting(1'b0, 1, 0, 1);
        queue_motion(100);
        drain();

        // zero pole pairs and zero rate
        apply_setting(1'b1, 0, 8191, 0);
        queue_motion(60);
        drain();

        // widest register values; receiver holds off while items pile up
        apply_setting(1'b0, 127, 16383, 131071);
        hold_request = 300;
        queue_motion(100);
        drain();

        for (int p = 0; p < 5; p++) begin
            apply_setting(1'($urandom()), $urandom_range(1, 64),
                          $urandom_range(0, TURN_SPAN - 1), $urandom_range(1, 100000));
            queue_motion(100);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("multiturn_angle_velocity_tracker test passed");
        else
            $display("multiturn_angle_velocity_tracker test failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("multiturn_angle_velocity_tracker test failed");
        $finish;
    end

endmodule
